// ----- rtl/abss_pkg.sv -----
package abss_pkg;

    // Slot codes
    localparam logic [1:0] SLOT_NONE = 2'd0;
    localparam logic [1:0] SLOT_A    = 2'd1;
    localparam logic [1:0] SLOT_B    = 2'd2;

    // Item kinds
    localparam logic OP_BOOT   = 1'b0;
    localparam logic OP_COMMIT = 1'b1;

    // Trial boots a pending slot gets before rollback
    localparam logic [1:0] MAX_TRIAL_BOOTS = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_A_BASE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_A_SIZE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_B_BASE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_B_SIZE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_RAM0_START  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_RAM0_END    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_RAM1_START  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_RAM1_END    = 3'd7;

    // Configuration reset values
    localparam logic [31:0] RST_SLOT_A_BASE = 32'h0801_0000;
    localparam logic [31:0] RST_SLOT_A_SIZE = 32'h0003_0000;
    localparam logic [31:0] RST_SLOT_B_BASE = 32'h0804_0000;
    localparam logic [31:0] RST_SLOT_B_SIZE = 32'h0004_0000;
    localparam logic [31:0] RST_RAM0_START  = 32'h2000_0000;
    localparam logic [31:0] RST_RAM0_END    = 32'h2002_0000;
    localparam logic [31:0] RST_RAM1_START  = 32'h1000_0000;
    localparam logic [31:0] RST_RAM1_END    = 32'h1001_0000;

    // Port widths
    localparam int unsigned S_TDATA_W = 136;
    localparam int unsigned M_TDATA_W = 16;

    typedef struct packed {
        logic [31:0] ram0_start;
        logic [31:0] ram0_end;
        logic [31:0] ram1_start;
        logic [31:0] ram1_end;
    } ram_win_t;

    typedef struct packed {
        logic [1:0] active;
        logic [1:0] pending;
        logic [1:0] confirmed;
        logic [1:0] trials;
        logic       rolled;
    } slot_state_t;

    typedef struct packed {
        logic [1:0] chosen;
        logic       commit_ok;
    } step_res_t;

endpackage

// ----- rtl/abss_vec_check.sv -----
module abss_vec_check (
    input  logic [31:0]        stack_word,
    input  logic [31:0]        reset_word,
    input  logic [31:0]        img_base,
    input  logic [31:0]        img_size,
    input  abss_pkg::ram_win_t ram_win,
    output logic               vec_ok
);

    logic [31:0] handler_addr;
    logic        stack_ok;
    logic        reset_ok;

    // Stack: word aligned, inside one RAM window (start exclusive, end inclusive)
    assign stack_ok = (stack_word[1:0] == 2'b00) &&
                      (((stack_word > ram_win.ram0_start) &&
                        (stack_word <= ram_win.ram0_end)) ||
                       ((stack_word > ram_win.ram1_start) &&
                        (stack_word <= ram_win.ram1_end)));

    // Reset handler: thumb bit set, address in [base, base + size) without wrap
    assign handler_addr = {reset_word[31:1], 1'b0};
    assign reset_ok     = reset_word[0] && (handler_addr >= img_base) &&
                          ((handler_addr - img_base) < img_size);

    assign vec_ok = stack_ok && reset_ok;

endmodule

// ----- rtl/abss_select.sv -----
module abss_select #(
    parameter logic [1:0] MAX_TRIALS = abss_pkg::MAX_TRIAL_BOOTS
) (
    input  logic                  op,
    input  logic [1:0]            commit_tgt,
    input  logic                  a_ok,
    input  logic                  b_ok,
    input  abss_pkg::slot_state_t cur_state,
    output abss_pkg::slot_state_t nxt_state,
    output abss_pkg::step_res_t   step_res
);

    function automatic logic slot_ok(input logic [1:0] s, input logic va, input logic vb);
        logic r;
        r = 1'b0;
        if (s == abss_pkg::SLOT_A) r = va;
        else if (s == abss_pkg::SLOT_B) r = vb;
        return r;
    endfunction

    logic done;

    always_comb begin
        nxt_state = cur_state;
        step_res  = '0;
        done      = 1'b0;
        if (op == abss_pkg::OP_BOOT) begin
            // Pending trial slot first
            if (slot_ok(cur_state.pending, a_ok, b_ok)) begin
                if (cur_state.confirmed == cur_state.pending) begin
                    nxt_state.active  = cur_state.pending;
                    nxt_state.pending = abss_pkg::SLOT_NONE;
                    nxt_state.trials  = 2'd0;
                    step_res.chosen   = cur_state.pending;
                    done = 1'b1;
                end else if (cur_state.trials < MAX_TRIALS) begin
                    nxt_state.active  = cur_state.pending;
                    nxt_state.trials  = cur_state.trials + 2'd1;
                    step_res.chosen   = cur_state.pending;
                    done = 1'b1;
                end else begin
                    // Out of trials: roll back and go on
                    nxt_state.rolled  = 1'b1;
                    nxt_state.pending = abss_pkg::SLOT_NONE;
                    nxt_state.trials  = 2'd0;
                end
            end
            if (!done && slot_ok(cur_state.confirmed, a_ok, b_ok)) begin
                nxt_state.active = cur_state.confirmed;
                nxt_state.trials = 2'd0;
                step_res.chosen  = cur_state.confirmed;
                done = 1'b1;
            end
            if (!done && slot_ok(cur_state.active, a_ok, b_ok)) begin
                step_res.chosen = cur_state.active;
                done = 1'b1;
            end
            if (!done && (a_ok || b_ok)) begin
                nxt_state.active    = a_ok ? abss_pkg::SLOT_A : abss_pkg::SLOT_B;
                nxt_state.confirmed = a_ok ? abss_pkg::SLOT_A : abss_pkg::SLOT_B;
                nxt_state.pending   = abss_pkg::SLOT_NONE;
                nxt_state.trials    = 2'd0;
                step_res.chosen     = a_ok ? abss_pkg::SLOT_A : abss_pkg::SLOT_B;
            end
        end else begin
            if (slot_ok(commit_tgt, a_ok, b_ok)) begin
                nxt_state.pending  = commit_tgt;
                nxt_state.active   = commit_tgt;
                nxt_state.trials   = 2'd0;
                nxt_state.rolled   = 1'b0;
                step_res.commit_ok = 1'b1;
            end
        end
    end

endmodule

// ----- rtl/ab_boot_slot_selector_unit.sv -----
// A/B boot slot selector: one boot request or install commit per word.
// Each word goes through the input register, then the result register, which drives m_tdata.
// Throughput: one word per cycle while m_tready holds; the slot state loop closes through
// the vector checks and the selection logic between the input and result registers.
// Reset (aresetn low, synchronous): slot state cleared, configuration back to defaults,
// both pipeline registers emptied.
module ab_boot_slot_selector_unit #(
    parameter logic [1:0] MAX_TRIALS = abss_pkg::MAX_TRIAL_BOOTS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Configuration write port
    input  logic                                   cfg_we,
    input  logic [abss_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [31:0]                            cfg_wdata,
    // Input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [1:0] commit target, [33:2] a_stack_word, [65:34] a_reset_word,
    // [97:66] b_stack_word, [129:98] b_reset_word, [135:130] zero
    input  logic [abss_pkg::S_TDATA_W-1:0]         s_tdata,
    // [0] op
    input  logic                                   s_tuser,
    // Result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [1:0] chosen slot, [2] commit_ok, [4:3] active_out, [6:5] pending_out,
    // [8:7] confirmed_out, [10:9] trials_out, [11] rollback_flag, [15:12] zero
    output logic [abss_pkg::M_TDATA_W-1:0]         m_tdata
);

    // Configuration registers
    logic [31:0]        slot_a_base_reg, slot_a_size_reg;
    logic [31:0]        slot_b_base_reg, slot_b_size_reg;
    abss_pkg::ram_win_t ram_win_reg;

    // Input stage
    logic        in_valid_reg;
    logic        in_op_reg;
    logic [1:0]  in_target_reg;
    logic [31:0] in_a_stack_reg, in_a_reset_reg, in_b_stack_reg, in_b_reset_reg;

    // Slot state and result stage
    abss_pkg::slot_state_t state_reg, state_next;
    abss_pkg::step_res_t   step_res;
    logic                  out_valid_reg;
    logic [11:0]           out_data_reg;

    logic a_ok, b_ok;
    logic advance;
    logic in_load;

    // Move the held word to the result register when the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_load  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_a_base_reg        <= abss_pkg::RST_SLOT_A_BASE;
            slot_a_size_reg        <= abss_pkg::RST_SLOT_A_SIZE;
            slot_b_base_reg        <= abss_pkg::RST_SLOT_B_BASE;
            slot_b_size_reg        <= abss_pkg::RST_SLOT_B_SIZE;
            ram_win_reg.ram0_start <= abss_pkg::RST_RAM0_START;
            ram_win_reg.ram0_end   <= abss_pkg::RST_RAM0_END;
            ram_win_reg.ram1_start <= abss_pkg::RST_RAM1_START;
            ram_win_reg.ram1_end   <= abss_pkg::RST_RAM1_END;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                abss_pkg::CFG_SLOT_A_BASE: slot_a_base_reg        <= cfg_wdata;
                abss_pkg::CFG_SLOT_A_SIZE: slot_a_size_reg        <= cfg_wdata;
                abss_pkg::CFG_SLOT_B_BASE: slot_b_base_reg        <= cfg_wdata;
                abss_pkg::CFG_SLOT_B_SIZE: slot_b_size_reg        <= cfg_wdata;
                abss_pkg::CFG_RAM0_START:  ram_win_reg.ram0_start <= cfg_wdata;
                abss_pkg::CFG_RAM0_END:    ram_win_reg.ram0_end   <= cfg_wdata;
                abss_pkg::CFG_RAM1_START:  ram_win_reg.ram1_start <= cfg_wdata;
                abss_pkg::CFG_RAM1_END:    ram_win_reg.ram1_end   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register: control reset, payload loaded on acceptance without reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_load) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_op_reg      <= s_tuser;
            in_target_reg  <= s_tdata[1:0];
            in_a_stack_reg <= s_tdata[33:2];
            in_a_reset_reg <= s_tdata[65:34];
            in_b_stack_reg <= s_tdata[97:66];
            in_b_reset_reg <= s_tdata[129:98];
        end
    end

    // Check both vectors in parallel
    abss_vec_check u_vec_a (
        .stack_word (in_a_stack_reg),
        .reset_word (in_a_reset_reg),
        .img_base   (slot_a_base_reg),
        .img_size   (slot_a_size_reg),
        .ram_win    (ram_win_reg),
        .vec_ok     (a_ok)
    );

    abss_vec_check u_vec_b (
        .stack_word (in_b_stack_reg),
        .reset_word (in_b_reset_reg),
        .img_base   (slot_b_base_reg),
        .img_size   (slot_b_size_reg),
        .ram_win    (ram_win_reg),
        .vec_ok     (b_ok)
    );

    abss_select #(
        .MAX_TRIALS (MAX_TRIALS)
    ) u_select (
        .op          (in_op_reg),
        .commit_tgt  (in_target_reg),
        .a_ok        (a_ok),
        .b_ok        (b_ok),
        .cur_state   (state_reg),
        .nxt_state   (state_next),
        .step_res    (step_res)
    );

    // Slot state advances together with the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {state_next.rolled, state_next.trials, state_next.confirmed,
                             state_next.pending, state_next.active,
                             step_res.commit_ok, step_res.chosen};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg};

    // A result is either a boot choice or a commit, never both
    a_res_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2] && (m_tdata[1:0] != abss_pkg::SLOT_NONE)))
        else $error("commit_ok and chosen slot both set");

    // No trial count without a pending slot, and never past the limit
    a_trials: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg.pending == abss_pkg::SLOT_NONE) |-> (state_reg.trials == 2'd0)) &&
        (state_reg.trials <= MAX_TRIALS))
        else $error("trial count inconsistent with pending slot");

    // Rollback flag only rises on a boot request that moved through
    a_rollback: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg.rolled) |-> $past(advance && (in_op_reg == abss_pkg::OP_BOOT)))
        else $error("rollback flag set outside a boot request");

    // An accepted commit leaves the target both pending and active
    a_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |->
            ((m_tdata[6:5] == m_tdata[4:3]) && (m_tdata[6:5] != abss_pkg::SLOT_NONE)))
        else $error("commit result without matching pending and active slot");

endmodule
